// File: rtl/core/bssi_pkg.sv
// types and codes shared by the bounded stack with sorted insert
package bssi_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_word;
        logic [4:0]         entry_count;
    } t_rsp;

endpackage

// File: rtl/core/bounded_stack_sorted_insert_unit.sv
// bounded lifo stack with remove-by-value and sorted insert
// push, clear, unused codes and refused requests respond straight from idle; pop first reads
//   the top word through the registered read port; remove scans down from the top, then moves
//   each entry above the match down; sorted insert moves each smaller entry up, then places it
// transactions: one at a time; the walk over the store visits one entry per cycle and cannot
//   stall; a new request waits for idle and for the response slot to free
// reset: entry count cleared to empty; stored words are not cleared
module bounded_stack_sorted_insert_unit #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bssi_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bssi_pkg::t_rsp o_out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_POP    = 6'b000010,
        S_RSRCH  = 6'b000100,
        S_RSHIFT = 6'b001000,
        S_INS    = 6'b010000,
        S_INSW   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic               r_out_valid, n_out_valid;
    bssi_pkg::t_rsp     r_out, n_out;

    // store ports
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               wr_en;

    logic accept;
    logic full;
    logic empty;

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // store with one write port and a registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = IW'(r_count - CW'(1));
        wr_addr     = r_idx;
        wr_data     = r_val;
        wr_en       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val             = i_in_data.value;
                    n_out.status      = bssi_pkg::ST_OK;
                    n_out.popped_word = '0;
                    unique case (i_in_data.req_type)
                        bssi_pkg::REQ_PUSH: begin
                            if (full) begin
                                n_out.status = bssi_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = IW'(r_count);
                                wr_data = i_in_data.value;
                                n_count = r_count + CW'(1);
                            end
                            n_out.entry_count = 5'(n_count);
                            n_out_valid       = 1'b1;
                        end
                        bssi_pkg::REQ_POP: begin
                            if (empty) begin
                                n_out.status      = bssi_pkg::ST_EMPTY;
                                n_out.entry_count = 5'(r_count);
                                n_out_valid       = 1'b1;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        bssi_pkg::REQ_REMOVE: begin
                            if (empty) begin
                                n_out.status      = bssi_pkg::ST_NOTFOUND;
                                n_out.entry_count = 5'(r_count);
                                n_out_valid       = 1'b1;
                            end else begin
                                n_idx   = IW'(r_count - CW'(1));
                                n_state = S_RSRCH;
                            end
                        end
                        bssi_pkg::REQ_INSERT: begin
                            if (full) begin
                                n_out.status      = bssi_pkg::ST_FULL;
                                n_out.entry_count = 5'(r_count);
                                n_out_valid       = 1'b1;
                            end else begin
                                n_idx   = IW'(r_count);
                                n_state = empty ? S_INSW : S_INS;
                            end
                        end
                        bssi_pkg::REQ_CLEAR: begin
                            n_count           = '0;
                            n_out.entry_count = '0;
                            n_out_valid       = 1'b1;
                        end
                        default: begin
                            n_out.entry_count = 5'(r_count);
                            n_out_valid       = 1'b1;
                        end
                    endcase
                end
            end

            // top word is on the read port
            S_POP: begin
                n_count           = r_count - CW'(1);
                n_out.popped_word = r_rd_data;
                n_out.entry_count = 5'(n_count);
                n_out_valid       = 1'b1;
                n_state           = S_IDLE;
            end

            // compare entry r_idx, walking down from the top
            S_RSRCH: begin
                if (r_rd_data == r_val) begin
                    rd_addr = IW'(CW'(r_idx) + CW'(1));
                    if ((CW'(r_idx) + CW'(1)) < r_count) begin
                        n_state = S_RSHIFT;
                    end else begin
                        n_count           = r_count - CW'(1);
                        n_out.entry_count = 5'(n_count);
                        n_out_valid       = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    rd_addr = r_idx - IW'(1);
                    if (r_idx == '0) begin
                        n_out.status      = bssi_pkg::ST_NOTFOUND;
                        n_out.entry_count = 5'(r_count);
                        n_out_valid       = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end

            // move entry r_idx+1 down into r_idx
            S_RSHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rd_data;
                rd_addr = IW'(CW'(r_idx) + CW'(2));
                n_idx   = r_idx + IW'(1);
                if ((CW'(r_idx) + CW'(2)) >= r_count) begin
                    n_count           = r_count - CW'(1);
                    n_out.entry_count = 5'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            // entry r_idx-1 is on the read port; move it up while smaller
            S_INS: begin
                wr_en = 1'b1;
                if (r_val > r_rd_data) begin
                    wr_data = r_rd_data;
                    rd_addr = r_idx - IW'(2);
                    n_idx   = r_idx - IW'(1);
                    if (r_idx == IW'(1)) begin
                        n_state = S_INSW;
                    end
                end else begin
                    n_count           = r_count + CW'(1);
                    n_out.entry_count = 5'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            // place the new word at r_idx
            S_INSW: begin
                wr_en             = 1'b1;
                n_count           = r_count + CW'(1);
                n_out.entry_count = 5'(n_count);
                n_out_valid       = 1'b1;
                n_state           = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_val <= n_val;
        r_out <= n_out;
    end

endmodule

// File: sim/tb_bounded_stack_sorted_insert_unit.sv
// testbench for the bounded stack with sorted insert: directed and random traffic checked against a predictor
`timescale 1ns / 1ps

module tb_bounded_stack_sorted_insert_unit;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 650;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;

    // request codes the block treats as no operation
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    // one outstanding transaction: the request and the response it should produce
    typedef struct packed {
        bssi_pkg::t_req req;
        bssi_pkg::t_rsp rsp;
    } t_awaited;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_ready = 1'b0;
    bssi_pkg::t_req i_in_data   = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    bssi_pkg::t_rsp o_out_data;

    // predictor state
    logic signed [31:0] stack_words [STACK_DEPTH];
    int                 stack_fill = 0;

    bssi_pkg::t_req     pending_requests[$];
    t_awaited           awaited_responses[$];
    logic signed [31:0] recent_words[$];

    int op_seen [8];
    int status_seen [4];
    int req_accepted   = 0;
    int rsp_checked    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    int holds_done     = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    t_awaited head_entry;

    bounded_stack_sorted_insert_unit #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // serve one request on the predicted stack and return its response
    function automatic bssi_pkg::t_rsp predict_stack_response(input bssi_pkg::t_req req);
        bssi_pkg::t_rsp rsp;
        int   lvl;
        int   k;
        int   i;
        rsp = '0;
        rsp.status = bssi_pkg::ST_OK;
        lvl = stack_fill;
        case (req.req_type)
            bssi_pkg::REQ_PUSH: begin
                if (lvl >= STACK_DEPTH) begin
                    rsp.status = bssi_pkg::ST_FULL;
                end else begin
                    stack_words[lvl] = req.value;
                    lvl++;
                end
            end
            bssi_pkg::REQ_POP: begin
                if (lvl == 0) begin
                    rsp.status = bssi_pkg::ST_EMPTY;
                end else begin
                    lvl--;
                    rsp.popped_word = stack_words[lvl];
                end
            end
            bssi_pkg::REQ_REMOVE: begin
                // search downwards from the top for the first equal word
                k = lvl;
                while (k > 0 && stack_words[k-1] != req.value) k--;
                if (k == 0) begin
                    rsp.status = bssi_pkg::ST_NOTFOUND;
                end else begin
                    for (i = k - 1; i < lvl - 1; i++) stack_words[i] = stack_words[i+1];
                    lvl--;
                end
            end
            bssi_pkg::REQ_INSERT: begin
                if (lvl >= STACK_DEPTH) begin
                    rsp.status = bssi_pkg::ST_FULL;
                end else begin
                    // pass over the run of strictly smaller top entries
                    k = lvl;
                    while (k > 0 && $signed(req.value) > $signed(stack_words[k-1])) k--;
                    for (i = lvl; i > k; i--) stack_words[i] = stack_words[i-1];
                    stack_words[k] = req.value;
                    lvl++;
                end
            end
            bssi_pkg::REQ_CLEAR: begin
                lvl = 0;
            end
            default: begin
            end
        endcase
        stack_fill = lvl;
        rsp.entry_count = 5'(lvl);
        op_seen[req.req_type]++;
        status_seen[rsp.status]++;
        return rsp;
    endfunction

    // idle length for either side: mostly none or short, now and then long
    function automatic int pick_delay();
        int r;
        if ((cycle_count / 1500) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // word for push or insert: corner values, repeats of recent words, or fully random
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            case ($urandom_range(0, 6))
                0: w = -32'sd2;
                1: w = -32'sd1;
                2: w = 32'sd0;
                3: w = 32'sd1;
                4: w = 32'sd2;
                5: w = 32'sh8000_0000;
                default: w = 32'sh7fff_ffff;
            endcase
        end else if (r < 45 && recent_words.size() != 0) begin
            w = recent_words[$urandom_range(0, recent_words.size() - 1)];
        end else begin
            w = $urandom;
        end
        recent_words.push_back(w);
        if (recent_words.size() > 24) void'(recent_words.pop_front());
        return w;
    endfunction

    task automatic add_request(input logic [2:0] op, input logic signed [31:0] val);
        pending_requests.push_back(bssi_pkg::t_req'({op, val}));
    endtask

    task automatic report_mismatch(input string what, input t_awaited entry,
                                   input bssi_pkg::t_rsp got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"[%0t] %s: req %0d value %0d | status exp %0d got %0d",
                      " | popped exp %0d got %0d | count exp %0d got %0d"},
                     $time, what, entry.req.req_type, entry.req.value,
                     entry.rsp.status, got.status,
                     entry.rsp.popped_word, got.popped_word,
                     entry.rsp.entry_count, got.entry_count);
    endtask

    // driver: predict each accepted transaction, then offer the next pending request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_responses.push_back(
                    t_awaited'({i_in_data, predict_stack_response(i_in_data)}));
                req_accepted <= req_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    i_in_data  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = pick_delay();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, twice in the run, so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && req_accepted >= 150) ||
                     (holds_done == 1 && req_accepted >= 450)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // monitor: compare each response transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rsp_checked++;
                if (awaited_responses.size() == 0) begin
                    report_mismatch("response with nothing outstanding", '0, o_out_data);
                end else begin
                    head_entry = awaited_responses.pop_front();
                    if (o_out_data.status !== head_entry.rsp.status ||
                        o_out_data.popped_word !== head_entry.rsp.popped_word ||
                        o_out_data.entry_count !== head_entry.rsp.entry_count)
                        report_mismatch("response mismatch", head_entry, o_out_data);
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = pick_delay();
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped at cycle limit with %0d responses outstanding",
                     awaited_responses.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_phase      phase;
        int          phase_left;
        int          random_sent;
        int          r;
        int          t_push;
        int          t_ins;
        int          t_rem;
        int          t_pop;
        logic [2:0]  op;
        logic signed [31:0] val;

        // directed: refusals on empty, spare codes, extremes, ordering and removal
        add_request(bssi_pkg::REQ_POP, 32'sd0);
        add_request(bssi_pkg::REQ_REMOVE, 32'sd0);
        add_request(REQ_SPARE_A, 32'sh1234_5678);
        add_request(REQ_SPARE_B, -32'sd1);
        add_request(REQ_SPARE_C, 32'sd0);
        add_request(bssi_pkg::REQ_PUSH, 32'sh8000_0000);
        add_request(bssi_pkg::REQ_PUSH, 32'sh7fff_ffff);
        add_request(bssi_pkg::REQ_PUSH, -32'sd1);
        add_request(bssi_pkg::REQ_PUSH, 32'sd0);
        add_request(bssi_pkg::REQ_INSERT, 32'sd0);
        add_request(bssi_pkg::REQ_INSERT, 32'sd5);
        add_request(bssi_pkg::REQ_INSERT, 32'sh8000_0000);
        add_request(bssi_pkg::REQ_INSERT, 32'sh7fff_ffff);
        add_request(bssi_pkg::REQ_REMOVE, -32'sd1);
        add_request(bssi_pkg::REQ_REMOVE, 32'sd12345);
        add_request(bssi_pkg::REQ_REMOVE, 32'sh7fff_ffff);
        add_request(bssi_pkg::REQ_POP, 32'sd0);
        add_request(bssi_pkg::REQ_POP, 32'sd0);
        add_request(bssi_pkg::REQ_CLEAR, 32'sd0);
        add_request(bssi_pkg::REQ_POP, 32'sd0);
        add_request(bssi_pkg::REQ_INSERT, -32'sd7);
        add_request(bssi_pkg::REQ_REMOVE, -32'sd7);
        add_request(bssi_pkg::REQ_PUSH, 32'sh5555_5555);
        add_request(bssi_pkg::REQ_PUSH, 32'shaaaa_aaaa);
        add_request(bssi_pkg::REQ_CLEAR, 32'sd0);

        // random: phases that push the stack toward its limit, drain it, or mix
        random_sent = 0;
        phase_left  = 0;
        phase       = PH_MIXED;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: phase = PH_FILL;
                    1: phase = PH_DRAIN;
                    default: phase = PH_MIXED;
                endcase
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if ($urandom_range(0, 99) < 2) begin
                case ($urandom_range(0, 2))
                    0: op = REQ_SPARE_A;
                    1: op = REQ_SPARE_B;
                    default: op = REQ_SPARE_C;
                endcase
                add_request(op, $urandom);
            end else begin
                case (phase)
                    PH_FILL: begin
                        t_push = 45; t_ins = 85; t_rem = 92; t_pop = 99;
                    end
                    PH_DRAIN: begin
                        t_push = 10; t_ins = 20; t_rem = 50; t_pop = 98;
                    end
                    default: begin
                        t_push = 30; t_ins = 55; t_rem = 75; t_pop = 96;
                    end
                endcase
                r = $urandom_range(0, 99);
                if (r < t_push) begin
                    op  = bssi_pkg::REQ_PUSH;
                    val = pick_value();
                end else if (r < t_ins) begin
                    op  = bssi_pkg::REQ_INSERT;
                    val = pick_value();
                end else if (r < t_rem) begin
                    op = bssi_pkg::REQ_REMOVE;
                    // mostly search for a word that was recently stored
                    if (recent_words.size() != 0 && $urandom_range(0, 99) < 75)
                        val = recent_words[$urandom_range(0, recent_words.size() - 1)];
                    else
                        val = $urandom;
                end else if (r < t_pop) begin
                    op  = bssi_pkg::REQ_POP;
                    val = $urandom;
                end else begin
                    op  = bssi_pkg::REQ_CLEAR;
                    val = $urandom;
                end
                add_request(op, val);
                random_sent++;
            end
        end

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (pending_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display({"%0d requests checked (push %0d, pop %0d, remove %0d, insert %0d,",
                  " clear %0d, spare codes %0d)"},
                 rsp_checked, op_seen[bssi_pkg::REQ_PUSH], op_seen[bssi_pkg::REQ_POP],
                 op_seen[bssi_pkg::REQ_REMOVE], op_seen[bssi_pkg::REQ_INSERT],
                 op_seen[bssi_pkg::REQ_CLEAR],
                 op_seen[REQ_SPARE_A] + op_seen[REQ_SPARE_B] + op_seen[REQ_SPARE_C]);
        $display({"outcomes: ok %0d, refused full %0d, refused empty %0d,",
                  " not found %0d; %0d bad responses"},
                 status_seen[bssi_pkg::ST_OK], status_seen[bssi_pkg::ST_FULL],
                 status_seen[bssi_pkg::ST_EMPTY], status_seen[bssi_pkg::ST_NOTFOUND],
                 mismatch_count);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bssi_pkg.sv
rtl/core/bounded_stack_sorted_insert_unit.sv
sim/tb_bounded_stack_sorted_insert_unit.sv
